// ----- rtl/core/dhssc_pkg.sv -----
// ---------------------------------------------------------------------------
// dhssc_pkg
// Shared types, codes and tables for the dual half-step stepper controller.
// ---------------------------------------------------------------------------
package dhssc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned DIV_W      = 32;
	localparam int unsigned DIV_CNT_W  = 5;
	localparam int unsigned DSR_W      = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_HZ   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_FLOOR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_CEIL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPD_CENTER = 3'd4;

	localparam logic [23:0] RST_TIMER_HZ   = 24'd4000000;
	localparam logic [11:0] RST_STEP_RATE  = 12'd340;
	localparam logic [15:0] RST_PER_FLOOR  = 16'd2000;
	localparam logic [15:0] RST_PER_CEIL   = 16'd60000;
	localparam logic [7:0]  RST_SPD_CENTER = 8'd127;

	localparam logic [7:0] START_BYTE = 8'd255;

	localparam logic [7:0] CMD_STEP_FWD = 8'd1;
	localparam logic [7:0] CMD_STEP_REV = 8'd2;
	localparam logic [7:0] CMD_CONT     = 8'd3;
	localparam logic [7:0] CMD_OFF      = 8'd4;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	localparam logic [1:0] PH_WAIT  = 2'd0;
	localparam logic [1:0] PH_CMDX  = 2'd1;
	localparam logic [1:0] PH_CMDY  = 2'd2;
	localparam logic [1:0] PH_SPEED = 2'd3;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

	typedef struct packed {
		logic [2:0]  idx;
		logic [1:0]  dir;
		logic [3:0]  pat;
		logic [15:0] period;
	} axis_t;

	typedef struct packed {
		axis_t st;
		logic  refreshed;
	} axis_upd_t;

	function automatic logic [3:0] step_pattern(input logic [2:0] idx);
		logic [3:0] p;
		unique case (idx)
			3'd0: p = 4'd5;
			3'd1: p = 4'd1;
			3'd2: p = 4'd9;
			3'd3: p = 4'd8;
			3'd4: p = 4'd10;
			3'd5: p = 4'd2;
			3'd6: p = 4'd6;
			3'd7: p = 4'd4;
			default: p = 4'd0;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/core/dual_half_step_stepper_controller_unit.sv -----
// ---------------------------------------------------------------------------
// dual_half_step_stepper_controller_unit
// Packet decoder, speed-to-period mapping and step timing for two axes.
// ---------------------------------------------------------------------------
// An accepted item goes through decode, then to emit for a byte item, via the
// timer step for a timer item, via apply for a plain packet end, and via two
// 32-step passes of the shared restoring divider, clamp and apply for a packet
// end that maps a speed. One item at a time: input stalls until emit. Async
// active-low reset sets state and config to defaults, both axes stopped and off.
// ---------------------------------------------------------------------------
module dual_half_step_stepper_controller_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [3:0]                           x_drive,
	output logic [3:0]                           y_drive,
	output logic                                 x_refreshed,
	output logic [2:0]                           x_position,
	output logic                                 y_refreshed,
	output logic [2:0]                           y_position,
	output logic [15:0]                          next_interval,
	output logic                                 interval_valid,
	input  logic                                 cfg_we,
	input  logic [dhssc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dhssc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_DIV1   = 8'b0000_0100,
		S_DIV2   = 8'b0000_1000,
		S_CLAMP  = 8'b0001_0000,
		S_APPLY  = 8'b0010_0000,
		S_TSTEP  = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [23:0] timer_hz_q;
	logic [11:0] rate_q;
	logic [15:0] floor_q;
	logic [15:0] ceil_q;
	logic [7:0]  center_q;

	logic [1:0]             phase_q;
	dhssc_pkg::axis_t       x_q, y_q;
	logic [31:0]            x_acc_q, y_acc_q;
	logic [dhssc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                   out_valid_q;

	logic        op_q;
	logic [7:0]  byte_q;
	logic [7:0]  held_x_q, held_y_q;
	logic [dhssc_pkg::DIV_W-1:0] nq_q;
	logic [dhssc_pkg::DSR_W-1:0] rem_q, dsr_q, denom_q;
	logic [23:0] fl_q;
	logic [31:0] map_q;
	logic        res_xr_q, res_yr_q, res_iv_q;
	logic [15:0] res_int_q;
	logic [3:0]  x_drive_q, y_drive_q;
	logic        x_ref_q, y_ref_q, iv_q;
	logic [2:0]  x_pos_q, y_pos_q;
	logic [15:0] int_q;

	logic [7:0]  mag;
	logic        need_div;
	logic [15:0] inc;
	logic [15:0] clamp_per;
	logic [15:0] lo_per;
	logic        emit_go;
	logic [dhssc_pkg::DSR_W:0]   div_shift, div_diff;
	logic                        div_ge;
	logic [dhssc_pkg::DSR_W-1:0] rem_nxt;
	logic [dhssc_pkg::DIV_W-1:0] nq_nxt;
	dhssc_pkg::axis_upd_t x_apply, y_apply, x_ts, y_ts;

	function automatic dhssc_pkg::axis_upd_t apply_cmd(
		input dhssc_pkg::axis_t a,
		input logic [7:0]       cmd,
		input logic [7:0]       spd,
		input logic [7:0]       ctr,
		input logic             rate_zero,
		input logic [15:0]      per,
		input logic [15:0]      ceil_v
	);
		dhssc_pkg::axis_upd_t u;
		u.st        = a;
		u.refreshed = 1'b0;
		unique case (cmd)
			dhssc_pkg::CMD_STEP_FWD, dhssc_pkg::CMD_STEP_REV: begin
				u.st.dir    = dhssc_pkg::DIR_STOP;
				u.st.idx    = (cmd == dhssc_pkg::CMD_STEP_FWD) ? a.idx + 3'd1 : a.idx - 3'd1;
				u.st.pat    = dhssc_pkg::step_pattern(u.st.idx);
				u.refreshed = 1'b1;
			end
			dhssc_pkg::CMD_CONT: begin
				if (spd == ctr) begin
					u.st.dir = dhssc_pkg::DIR_STOP;
					u.st.pat = 4'd0;
				end else begin
					if (rate_zero) begin
						u.st.period = ceil_v;
						u.st.dir    = dhssc_pkg::DIR_STOP;
					end else begin
						u.st.period = per;
						u.st.dir    = (spd > ctr) ? dhssc_pkg::DIR_FWD : dhssc_pkg::DIR_REV;
					end
					u.st.pat    = dhssc_pkg::step_pattern(a.idx);
					u.refreshed = 1'b1;
				end
			end
			dhssc_pkg::CMD_OFF: begin
				u.st.dir = dhssc_pkg::DIR_STOP;
				u.st.pat = 4'd0;
			end
			default: ;
		endcase
		return u;
	endfunction

	function automatic dhssc_pkg::axis_upd_t timer_step(
		input dhssc_pkg::axis_t a,
		input logic [31:0]      acc
	);
		dhssc_pkg::axis_upd_t u;
		u.st        = a;
		u.refreshed = 1'b0;
		if (a.dir != dhssc_pkg::DIR_STOP && acc >= {16'd0, a.period}) begin
			u.st.idx    = (a.dir == dhssc_pkg::DIR_FWD) ? a.idx + 3'd1 : a.idx - 3'd1;
			u.st.pat    = dhssc_pkg::step_pattern(u.st.idx);
			u.refreshed = 1'b1;
		end
		return u;
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign emit_go  = !out_valid_q || !out_stall;

	assign mag      = (byte_q > center_q) ? byte_q - center_q : center_q - byte_q;
	assign need_div = (held_x_q == dhssc_pkg::CMD_CONT || held_y_q == dhssc_pkg::CMD_CONT)
		&& (byte_q != center_q) && (rate_q != 12'd0);

	always_comb begin
		inc = ceil_q;
		if (x_q.dir != dhssc_pkg::DIR_STOP)
			inc = x_q.period;
		if (y_q.dir != dhssc_pkg::DIR_STOP) begin
			if (x_q.dir == dhssc_pkg::DIR_STOP || y_q.period < inc)
				inc = y_q.period;
		end
		if (inc == 16'd0)
			inc = ceil_q;
	end

	// restoring divider, one quotient bit a cycle
	assign div_shift = {rem_q, nq_q[dhssc_pkg::DIV_W-1]};
	assign div_ge    = (div_shift >= {1'b0, dsr_q});
	assign div_diff  = div_shift - {1'b0, dsr_q};
	assign rem_nxt   = div_ge ? div_diff[dhssc_pkg::DSR_W-1:0] : div_shift[dhssc_pkg::DSR_W-1:0];
	assign nq_nxt    = {nq_q[dhssc_pkg::DIV_W-2:0], div_ge};

	always_comb begin
		lo_per    = (map_q[15:0] < floor_q) ? floor_q : map_q[15:0];
		clamp_per = (map_q[31:16] != 16'd0 || lo_per > ceil_q) ? ceil_q : lo_per;
	end

	assign x_apply = apply_cmd(x_q, held_x_q, byte_q, center_q, rate_q == 12'd0,
		clamp_per, ceil_q);
	assign y_apply = apply_cmd(y_q, held_y_q, byte_q, center_q, rate_q == 12'd0,
		clamp_per, ceil_q);
	assign x_ts    = timer_step(x_q, x_acc_q);
	assign y_ts    = timer_step(y_q, y_acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			timer_hz_q  <= dhssc_pkg::RST_TIMER_HZ;
			rate_q      <= dhssc_pkg::RST_STEP_RATE;
			floor_q     <= dhssc_pkg::RST_PER_FLOOR;
			ceil_q      <= dhssc_pkg::RST_PER_CEIL;
			center_q    <= dhssc_pkg::RST_SPD_CENTER;
			phase_q     <= dhssc_pkg::PH_WAIT;
			x_q         <= '{idx: 3'd0, dir: dhssc_pkg::DIR_STOP, pat: 4'd0,
				period: dhssc_pkg::RST_PER_CEIL};
			y_q         <= '{idx: 3'd0, dir: dhssc_pkg::DIR_STOP, pat: 4'd0,
				period: dhssc_pkg::RST_PER_CEIL};
			x_acc_q     <= 32'd0;
			y_acc_q     <= 32'd0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dhssc_pkg::CFG_TIMER_HZ:   timer_hz_q <= cfg_data;
					dhssc_pkg::CFG_STEP_RATE:  rate_q     <= cfg_data[11:0];
					dhssc_pkg::CFG_PER_FLOOR:  floor_q    <= cfg_data[15:0];
					dhssc_pkg::CFG_PER_CEIL:   ceil_q     <= cfg_data[15:0];
					dhssc_pkg::CFG_SPD_CENTER: center_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (state_q == S_EMIT && emit_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (op_q) begin
						x_acc_q <= x_acc_q + {16'd0, inc};
						y_acc_q <= y_acc_q + {16'd0, inc};
						state_q <= S_TSTEP;
					end else begin
						unique case (phase_q)
							dhssc_pkg::PH_WAIT: begin
								if (byte_q == dhssc_pkg::START_BYTE)
									phase_q <= dhssc_pkg::PH_CMDX;
								state_q <= S_EMIT;
							end
							dhssc_pkg::PH_CMDX: begin
								phase_q <= dhssc_pkg::PH_CMDY;
								state_q <= S_EMIT;
							end
							dhssc_pkg::PH_CMDY: begin
								phase_q <= dhssc_pkg::PH_SPEED;
								state_q <= S_EMIT;
							end
							default: begin
								phase_q <= dhssc_pkg::PH_WAIT;
								cnt_q   <= '0;
								state_q <= need_div ? S_DIV1 : S_APPLY;
							end
						endcase
					end
				end
				S_DIV1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == dhssc_pkg::DIV_LAST)
						state_q <= S_DIV2;
				end
				S_DIV2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == dhssc_pkg::DIV_LAST)
						state_q <= S_CLAMP;
				end
				S_CLAMP: state_q <= S_APPLY;
				S_APPLY: begin
					x_q     <= x_apply.st;
					y_q     <= y_apply.st;
					state_q <= S_EMIT;
				end
				S_TSTEP: begin
					x_q <= x_ts.st;
					y_q <= y_ts.st;
					if (x_ts.refreshed)
						x_acc_q <= 32'd0;
					if (y_ts.refreshed)
						y_acc_q <= 32'd0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= opcode;
			byte_q <= rx_byte;
		end
		unique case (state_q)
			S_DECODE: begin
				res_xr_q  <= 1'b0;
				res_yr_q  <= 1'b0;
				res_int_q <= op_q ? inc : 16'd0;
				res_iv_q  <= op_q;
				if (!op_q) begin
					if (phase_q == dhssc_pkg::PH_CMDX)
						held_x_q <= byte_q;
					else if (phase_q == dhssc_pkg::PH_CMDY)
						held_y_q <= byte_q;
				end
				nq_q    <= {8'd0, timer_hz_q};
				rem_q   <= '0;
				dsr_q   <= {8'd0, rate_q};
				denom_q <= {8'd0, rate_q} * {12'd0, mag};
			end
			S_DIV1: begin
				if (cnt_q == dhssc_pkg::DIV_LAST) begin
					fl_q  <= nq_nxt[23:0];
					nq_q  <= {1'b0, timer_hz_q, 7'd0};
					rem_q <= '0;
					dsr_q <= denom_q;
				end else begin
					nq_q  <= nq_nxt;
					rem_q <= rem_nxt;
				end
			end
			S_DIV2: begin
				nq_q  <= nq_nxt;
				rem_q <= rem_nxt;
			end
			S_CLAMP: map_q <= (nq_q < {8'd0, fl_q}) ? {8'd0, fl_q} : nq_q;
			S_APPLY: begin
				res_xr_q <= x_apply.refreshed;
				res_yr_q <= y_apply.refreshed;
			end
			S_TSTEP: begin
				res_xr_q <= x_ts.refreshed;
				res_yr_q <= y_ts.refreshed;
			end
			S_EMIT: begin
				if (emit_go) begin
					x_drive_q <= x_q.pat;
					y_drive_q <= y_q.pat;
					x_ref_q   <= res_xr_q;
					y_ref_q   <= res_yr_q;
					x_pos_q   <= x_q.idx;
					y_pos_q   <= y_q.idx;
					int_q     <= res_int_q;
					iv_q      <= res_iv_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign x_drive        = x_drive_q;
	assign y_drive        = y_drive_q;
	assign x_refreshed    = x_ref_q;
	assign y_refreshed    = y_ref_q;
	assign x_position     = x_pos_q;
	assign y_position     = y_pos_q;
	assign next_interval  = int_q;
	assign interval_valid = iv_q;

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 || state_q == S_DIV2) |-> (rem_q < dsr_q))
		else $error("divider remainder not below divisor");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result shown outside emit");

	a_x_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TSTEP) |=> (x_q.dir == dhssc_pkg::DIR_STOP
			|| x_acc_q < {16'd0, x_q.period} || x_q.period == 16'd0))
		else $error("X accumulator at period after step");

	a_y_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TSTEP) |=> (y_q.dir == dhssc_pkg::DIR_STOP
			|| y_acc_q < {16'd0, y_q.period} || y_q.period == 16'd0))
		else $error("Y accumulator at period after step");

endmodule

// ----- bench/dhssc_tb_pkg.sv -----
// ---------------------------------------------------------------------------
// dhssc_tb_pkg
// Item codes shared by the stepper controller bench and its monitor.
// ---------------------------------------------------------------------------
package dhssc_tb_pkg;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

endpackage

// ----- bench/dhssc_drive_monitor.sv -----
// ---------------------------------------------------------------------------
// dhssc_drive_monitor
// Watches the item and result channels of the stepper controller, keeps its
// own copy of the packet decoder, speed mapping and step timing, and checks
// every result field against the oldest predicted drive state.
// ---------------------------------------------------------------------------
module dhssc_drive_monitor
	import dhssc_pkg::*;
	import dhssc_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  opcode,
	input  logic [7:0]            rx_byte,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [3:0]            x_drive,
	input  logic [3:0]            y_drive,
	input  logic                  x_refreshed,
	input  logic [2:0]            x_position,
	input  logic                  y_refreshed,
	input  logic [2:0]            y_position,
	input  logic [15:0]           next_interval,
	input  logic                  interval_valid,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    pending,
	output int                    mismatch_count
);

	// half-step coil patterns, index 0 in the low nibble
	localparam logic [31:0] HALF_STEP = {4'd4, 4'd6, 4'd2, 4'd10, 4'd8, 4'd9, 4'd1, 4'd5};

	typedef struct packed {
		logic [3:0]  x_drive;
		logic [3:0]  y_drive;
		logic        x_refreshed;
		logic [2:0]  x_position;
		logic        y_refreshed;
		logic [2:0]  y_position;
		logic [15:0] next_interval;
		logic        interval_valid;
	} drive_res_t;

	logic [23:0] tick_hz;
	logic [11:0] step_rate;
	logic [15:0] per_lo;
	logic [15:0] per_hi;
	logic [7:0]  center;

	logic [1:0]  phase;
	logic [7:0]  cmd_x;
	logic [7:0]  cmd_y;
	axis_t       x_st;
	axis_t       y_st;
	logic [31:0] x_acc;
	logic [31:0] y_acc;

	drive_res_t  drive_expect_q[$];

	function automatic logic [3:0] coil(input logic [2:0] idx);
		return HALF_STEP[4*idx +: 4];
	endfunction

	function automatic axis_t run_cmd(input axis_t a, input logic [7:0] cmd,
		input logic [7:0] spd, output logic refr);
		logic [7:0]      mag;
		longint unsigned q;
		longint unsigned dvs;
		longint unsigned lim;
		refr = 1'b0;
		case (cmd)
			CMD_STEP_FWD, CMD_STEP_REV: begin
				a.dir = DIR_STOP;
				a.idx = a.idx + ((cmd == CMD_STEP_FWD) ? 3'd1 : 3'd7);
				a.pat = coil(a.idx);
				refr  = 1'b1;
			end
			CMD_CONT: begin
				if (spd == center) begin
					a.dir = DIR_STOP;
					a.pat = 4'd0;
				end else begin
					mag = (spd > center) ? spd - center : center - spd;
					if (step_rate == 12'd0) begin
						a.period = per_hi;
						a.dir    = DIR_STOP;
					end else begin
						q   = tick_hz;
						q   = q * 128;
						dvs = step_rate;
						dvs = dvs * mag;
						q   = q / dvs;
						lim = tick_hz / step_rate;
						if (q < lim) q = lim;
						if (q < per_lo) q = per_lo;
						if (q > per_hi) q = per_hi;
						a.period = q[15:0];
						a.dir    = (spd > center) ? DIR_FWD : DIR_REV;
					end
					a.pat = coil(a.idx);
					refr  = 1'b1;
				end
			end
			CMD_OFF: begin
				a.dir = DIR_STOP;
				a.pat = 4'd0;
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic axis_t tick_axis(input axis_t a, inout logic [31:0] acc,
		output logic refr);
		refr = 1'b0;
		if (a.dir != DIR_STOP && acc >= {16'd0, a.period}) begin
			a.idx = a.idx + ((a.dir == DIR_FWD) ? 3'd1 : 3'd7);
			a.pat = coil(a.idx);
			acc   = 32'd0;
			refr  = 1'b1;
		end
		return a;
	endfunction

	function automatic drive_res_t predict_drive(input logic op, input logic [7:0] b);
		drive_res_t  r;
		logic        xr;
		logic        yr;
		logic [31:0] inc;
		xr  = 1'b0;
		yr  = 1'b0;
		inc = 32'd0;
		if (op == OP_BYTE) begin
			case (phase)
				PH_WAIT: if (b == START_BYTE) phase = PH_CMDX;
				PH_CMDX: begin
					cmd_x = b;
					phase = PH_CMDY;
				end
				PH_CMDY: begin
					cmd_y = b;
					phase = PH_SPEED;
				end
				default: begin
					x_st  = run_cmd(x_st, cmd_x, b, xr);
					y_st  = run_cmd(y_st, cmd_y, b, yr);
					phase = PH_WAIT;
				end
			endcase
		end else begin
			inc = per_hi;
			if (x_st.dir != DIR_STOP) inc = x_st.period;
			if (y_st.dir != DIR_STOP && (x_st.dir == DIR_STOP || y_st.period < inc))
				inc = y_st.period;
			if (inc == 32'd0) inc = per_hi;
			x_acc = x_acc + inc;
			y_acc = y_acc + inc;
			x_st  = tick_axis(x_st, x_acc, xr);
			y_st  = tick_axis(y_st, y_acc, yr);
		end
		r.x_drive        = x_st.pat;
		r.y_drive        = y_st.pat;
		r.x_refreshed    = xr;
		r.x_position     = x_st.idx;
		r.y_refreshed    = yr;
		r.y_position     = y_st.idx;
		r.next_interval  = inc[15:0];
		r.interval_valid = (op == OP_TICK);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		drive_res_t want;
		if (!arst_n) begin
			tick_hz        = RST_TIMER_HZ;
			step_rate      = RST_STEP_RATE;
			per_lo         = RST_PER_FLOOR;
			per_hi         = RST_PER_CEIL;
			center         = RST_SPD_CENTER;
			phase          = PH_WAIT;
			cmd_x          = 8'd0;
			cmd_y          = 8'd0;
			x_st           = '{idx: 3'd0, dir: DIR_STOP, pat: 4'd0, period: RST_PER_CEIL};
			y_st           = x_st;
			x_acc          = 32'd0;
			y_acc          = 32'd0;
			drive_expect_q.delete();
			pending        = 0;
			mismatch_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drive_expect_q.size() == 0) begin
					$error("result with no item outstanding");
					mismatch_count++;
				end else begin
					want = drive_expect_q.pop_front();
					check_field("x_drive", want.x_drive, x_drive);
					check_field("y_drive", want.y_drive, y_drive);
					check_field("x_refreshed", want.x_refreshed, x_refreshed);
					check_field("x_position", want.x_position, x_position);
					check_field("y_refreshed", want.y_refreshed, y_refreshed);
					check_field("y_position", want.y_position, y_position);
					check_field("next_interval", want.next_interval, next_interval);
					check_field("interval_valid", want.interval_valid, interval_valid);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMER_HZ:   tick_hz   = cfg_data[23:0];
					CFG_STEP_RATE:  step_rate = cfg_data[11:0];
					CFG_PER_FLOOR:  per_lo    = cfg_data[15:0];
					CFG_PER_CEIL:   per_hi    = cfg_data[15:0];
					CFG_SPD_CENTER: center    = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				drive_expect_q.push_back(predict_drive(opcode, rx_byte));
			pending = drive_expect_q.size();
		end
	end

endmodule

// ----- bench/dual_half_step_stepper_controller_unit_tb.sv -----
// ---------------------------------------------------------------------------
// dual_half_step_stepper_controller_unit_tb
// Drives bytes and timer ticks into the two-axis stepper controller with
// random gaps and output stalls, over several register settings. A short
// directed run covers steps, continuous motion, stop and ignored commands;
// random packets and tick bursts follow. The monitor checks all results.
// ---------------------------------------------------------------------------
module dual_half_step_stepper_controller_unit_tb;
	import dhssc_pkg::*;
	import dhssc_tb_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid;
	logic                  in_stall;
	logic                  opcode;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [3:0]            x_drive;
	logic [3:0]            y_drive;
	logic                  x_refreshed;
	logic [2:0]            x_position;
	logic                  y_refreshed;
	logic [2:0]            y_position;
	logic [15:0]           next_interval;
	logic                  interval_valid;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int                    mismatches;
	int                    outstanding;
	int                    taken = 0;
	int                    items_sent = 0;
	logic [7:0]            cur_center;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dual_half_step_stepper_controller_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.x_drive        (x_drive),
		.y_drive        (y_drive),
		.x_refreshed    (x_refreshed),
		.x_position     (x_position),
		.y_refreshed    (y_refreshed),
		.y_position     (y_position),
		.next_interval  (next_interval),
		.interval_valid (interval_valid),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	dhssc_drive_monitor u_drive_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.x_drive        (x_drive),
		.y_drive        (y_drive),
		.x_refreshed    (x_refreshed),
		.x_position     (x_position),
		.y_refreshed    (y_refreshed),
		.y_position     (y_position),
		.next_interval  (next_interval),
		.interval_valid (interval_valid),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pending        (outstanding),
		.mismatch_count (mismatches)
	);

	always @(posedge clk)
		if (out_valid && !out_stall) taken <= taken + 1;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [7:0] rand_cmd();
		if ($urandom_range(0, 99) < 85) return 8'($urandom_range(CMD_STEP_FWD, CMD_OFF));
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] rand_speed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return cur_center + 8'($urandom_range(0, 6)) - 8'd3;
		if (r < 40) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if (r < 45) return cur_center;
		return 8'($urandom);
	endfunction

	task automatic send_item(input logic op, input logic [7:0] b);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// ticks may fall between packet bytes; they leave the decoder alone
	task automatic send_packet(input logic [7:0] cx, input logic [7:0] cy,
		input logic [7:0] spd, input bit mix_ticks);
		logic [7:0] pkt [4];
		pkt = '{START_BYTE, cx, cy, spd};
		foreach (pkt[i]) begin
			if (mix_ticks && i > 0 && $urandom_range(0, 9) == 0)
				send_item(OP_TICK, 8'($urandom));
			send_item(OP_BYTE, pkt[i]);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [23:0] hz, input logic [11:0] rate,
		input logic [15:0] lo_per, input logic [15:0] hi_per, input logic [7:0] ctr);
		logic [CFG_IDX_W-1:0] spare;
		spare = CFG_SPD_CENTER + CFG_IDX_W'($urandom_range(1, 3));
		put_reg(CFG_TIMER_HZ, hz);
		put_reg(CFG_STEP_RATE, CFG_DATA_W'(rate));
		put_reg(CFG_PER_FLOOR, CFG_DATA_W'(lo_per));
		put_reg(CFG_PER_CEIL, CFG_DATA_W'(hi_per));
		put_reg(CFG_SPD_CENTER, CFG_DATA_W'(ctr));
		put_reg(spare, CFG_DATA_W'($urandom));
		cfg_we     <= 1'b0;
		cur_center = ctr;
	endtask

	task automatic random_phase(input int n);
		int stop_at;
		int r;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_packet(rand_cmd(), rand_cmd(), rand_speed(), 1'b1);
			else if (r < 85)
				repeat ($urandom_range(1, 10)) send_item(OP_TICK, 8'($urandom));
			else if (r < 93)
				send_item(OP_BYTE, 8'($urandom));
			else begin
				// truncated packet; later bytes get taken as its tail
				send_item(OP_BYTE, START_BYTE);
				repeat ($urandom_range(0, 2)) send_item(OP_BYTE, rand_cmd());
			end
		end
	endtask

	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : receiver
		int len;
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && taken >= 300) begin
				// long hold-off so the controller backs up into its input
				held = 1'b1;
				out_stall <= 1'b1;
				len = 600;
			end else if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				len = 1 + gap_len();
			end else begin
				out_stall <= 1'b0;
				len = $urandom_range(1, 40);
			end
			repeat (len) @(posedge clk);
		end
	end

	initial begin : stimulus
		in_valid   <= 1'b0;
		opcode     <= OP_BYTE;
		rx_byte    <= 8'd0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_TIMER_HZ;
		cfg_data   <= '0;
		cur_center = RST_SPD_CENTER;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h00);
		send_packet(CMD_STEP_FWD, CMD_STEP_REV, 8'h00, 1'b0);
		send_packet(CMD_CONT, CMD_CONT, 8'hFF, 1'b0);
		send_item(OP_TICK, 8'hFF);
		send_packet(CMD_CONT, CMD_OFF, 8'h00, 1'b0);
		send_item(OP_TICK, 8'h5A);
		send_packet(CMD_CONT, CMD_CONT, RST_SPD_CENTER, 1'b0);
		send_packet(8'h09, START_BYTE, 8'h05, 1'b0);
		drain();

		// zero ceiling gives a zero period; a later tick must fall back to the ceiling
		program_regs(RST_TIMER_HZ, RST_STEP_RATE, RST_PER_FLOOR, 16'd0, RST_SPD_CENTER);
		send_packet(CMD_CONT, CMD_STEP_FWD, 8'd200, 1'b0);
		send_item(OP_TICK, 8'h00);
		drain();
		program_regs(RST_TIMER_HZ, RST_STEP_RATE, RST_PER_FLOOR, 16'd3000, RST_SPD_CENTER);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: program_regs(RST_TIMER_HZ, RST_STEP_RATE, RST_PER_FLOOR, RST_PER_CEIL,
					RST_SPD_CENTER);
				1: program_regs(24'd16000000, 12'd4095, 16'd1, 16'd65535, 8'd0);
				2: program_regs(24'd1, 12'd1, 16'd65535, 16'd1, 8'd255);
				4: begin
					// zero step rate: continuous command stops the axis
					program_regs(24'($urandom_range(1, 16000000)), 12'd0,
						16'($urandom_range(1, 4000)), 16'($urandom_range(2000, 65535)),
						8'($urandom));
					send_packet(CMD_CONT, CMD_CONT, cur_center + 8'd50, 1'b0);
				end
				default: program_regs(24'($urandom_range(1, 16000000)),
					12'($urandom_range(1, 4095)), 16'($urandom_range(1, 4000)),
					16'($urandom_range(2000, 65535)), 8'($urandom));
			endcase
			random_phase(280);
			drain();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
